>>> src/cbe_pkg.sv
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared types, constants and fixed-point helpers for the cubic Bezier easing
// unit. All values are signed fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
package cbe_pkg;

	// Fixed-point format.
	localparam int FRAC_BITS = 14;
	localparam int ONE       = 1 << FRAC_BITS;

	// Default number of Newton iterations.
	localparam int NEWTON_STEPS = 6;

	// Slope magnitude under which solving stops.
	localparam int SLOPE_MIN = 2;

	// Widths: curve parameter, products, quotient, remainder, slope magnitude.
	localparam int UW = FRAC_BITS + 1;
	localparam int PW = 24;
	localparam int QW = 16;
	localparam int DW = 19;
	localparam int NW = DW;
	localparam int RW = NW + FRAC_BITS + 1;
	localparam int CW = DW + QW;

	// Configuration register indexes.
	localparam logic [1:0] CFG_CTRL1_X = 2'd0;
	localparam logic [1:0] CFG_CTRL1_Y = 2'd1;
	localparam logic [1:0] CFG_CTRL2_X = 2'd2;
	localparam logic [1:0] CFG_CTRL2_Y = 2'd3;

	// Item carried along the solver chain.
	typedef struct packed {
		logic [UW-1:0] t;
		logic [UW-1:0] u;
		logic          done;
	} cbe_item_t;

	// Product scaled by 2^FRAC_BITS, rounded to nearest, ties away from zero.
	function automatic logic signed [PW-1:0] fx_mul(input logic signed [PW-1:0] a,
			input logic signed [PW-1:0] b);
		logic [PW-1:0]   ma;
		logic [PW-1:0]   mb;
		logic [2*PW-1:0] p;
		logic [PW-1:0]   r;
		ma = a[PW-1] ? PW'(-a) : PW'(a);
		mb = b[PW-1] ? PW'(-b) : PW'(b);
		p  = ma * mb;
		r  = PW'((p + (2*PW)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
		return (a[PW-1] ^ b[PW-1]) ? -$signed(r) : $signed(r);
	endfunction

endpackage

>>> src/cbe_newton.sv
// ----------------------------------------------------------------------------
// cbe_newton
// One pipelined Newton step: evaluates x(u) and its slope, divides the error
// by the slope one quotient bit per stage, and updates u with clamping.
// ----------------------------------------------------------------------------
module cbe_newton (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_vld,
	input  cbe_pkg::cbe_item_t       in_item,
	input  logic [cbe_pkg::UW-1:0]   x1,
	input  logic [cbe_pkg::UW-1:0]   x2,
	output logic                     out_vld,
	output cbe_pkg::cbe_item_t       out_item
);

	localparam int PW = cbe_pkg::PW;
	localparam int UW = cbe_pkg::UW;
	localparam int QW = cbe_pkg::QW;
	localparam int DW = cbe_pkg::DW;
	localparam int NW = cbe_pkg::NW;
	localparam int RW = cbe_pkg::RW;
	localparam int CW = cbe_pkg::CW;
	localparam int FB = cbe_pkg::FRAC_BITS;

	// Control points as signed product operands.
	logic signed [PW-1:0] x1_w, x2_w, dx21_w, omx2_w;
	assign x1_w   = PW'(x1);
	assign x2_w   = PW'(x2);
	assign dx21_w = x2_w - x1_w;
	assign omx2_w = PW'(cbe_pkg::ONE) - x2_w;

	// Stage 1: basis terms.
	logic                 vld_s1;
	cbe_pkg::cbe_item_t   it_s1;
	logic signed [PW-1:0] inv_s1, a_s1, b_s1, iu_s1;
	logic signed [PW-1:0] u_w, inv_w;
	assign u_w   = PW'(in_item.u);
	assign inv_w = PW'(cbe_pkg::ONE) - u_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1  <= in_item;
			inv_s1 <= inv_w;
			a_s1   <= cbe_pkg::fx_mul(inv_w, inv_w);
			b_s1   <= cbe_pkg::fx_mul(u_w, u_w);
			iu_s1  <= cbe_pkg::fx_mul(inv_w, u_w);
		end
	end

	// Stage 2: cubic terms and slope partial products.
	logic                 vld_s2;
	cbe_pkg::cbe_item_t   it_s2;
	logic signed [PW-1:0] au_s2, invb_s2, bu_s2, sa_s2, siu_s2, sb_s2;
	logic signed [PW-1:0] u1_w;
	assign u1_w = PW'(it_s1.u);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s2   <= it_s1;
			au_s2   <= cbe_pkg::fx_mul(a_s1, u1_w);
			invb_s2 <= cbe_pkg::fx_mul(inv_s1, b_s1);
			bu_s2   <= cbe_pkg::fx_mul(b_s1, u1_w);
			sa_s2   <= cbe_pkg::fx_mul(a_s1, x1_w);
			siu_s2  <= cbe_pkg::fx_mul(iu_s1, dx21_w);
			sb_s2   <= cbe_pkg::fx_mul(b_s1, omx2_w);
		end
	end

	// Stage 3: weighted x terms and the slope sum.
	logic                 vld_s3;
	cbe_pkg::cbe_item_t   it_s3;
	logic signed [PW-1:0] xa_s3, xb_s3, bu_s3, dx_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s3 <= it_s2;
			xa_s3 <= cbe_pkg::fx_mul(au_s2, x1_w);
			xb_s3 <= cbe_pkg::fx_mul(invb_s2, x2_w);
			bu_s3 <= bu_s2;
			dx_s3 <= PW'(3 * sa_s2 + 6 * siu_s2 + 3 * sb_s2);
		end
	end

	// Stage 4: error against the target time, magnitudes and signs.
	logic                 vld_s4;
	cbe_pkg::cbe_item_t   it_s4;
	logic [NW-1:0]        nm_s4;
	logic [DW-1:0]        dm_s4;
	logic                 neg_s4, flat_s4;
	logic signed [PW-1:0] err_w;
	assign err_w = PW'(3 * xa_s3 + 3 * xb_s3 + bu_s3 - PW'(it_s3.t));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s4   <= it_s3;
			nm_s4   <= err_w[PW-1] ? NW'(-err_w) : NW'(err_w);
			dm_s4   <= dx_s3[PW-1] ? DW'(-dx_s3) : DW'(dx_s3);
			neg_s4  <= err_w[PW-1] ^ dx_s3[PW-1];
			flat_s4 <= (dx_s3 > -PW'(cbe_pkg::SLOPE_MIN)) && (dx_s3 < PW'(cbe_pkg::SLOPE_MIN));
		end
	end

	// Stage 5: rounded dividend and quotient range check.
	logic [RW-1:0] num_w;
	logic [CW:0]   lim_w;
	assign num_w = {nm_s4, {FB{1'b0}}} + RW'(dm_s4 >> 1);
	assign lim_w = {1'b0, dm_s4, {QW{1'b0}}};

	// Divider chain: index 0 is stage 5, index k after quotient bit QW-k.
	logic                     dv_vld_s  [0:QW];
	cbe_pkg::cbe_item_t       dv_it_s   [0:QW];
	logic [RW-1:0]            dv_rem_s  [0:QW];
	logic [QW-1:0]            dv_q_s    [0:QW];
	logic [DW-1:0]            dv_dm_s   [0:QW];
	logic                     dv_neg_s  [0:QW];
	logic                     dv_flat_s [0:QW];
	logic                     dv_ovf_s  [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (en) begin
			dv_vld_s[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_it_s[0]   <= it_s4;
			dv_rem_s[0]  <= num_w;
			dv_q_s[0]    <= '0;
			dv_dm_s[0]   <= dm_s4;
			dv_neg_s[0]  <= neg_s4;
			dv_flat_s[0] <= flat_s4;
			dv_ovf_s[0]  <= ({2'b00, num_w} >= lim_w);
		end
	end

	// One restoring quotient bit per stage, most significant first.
	for (genvar k = 1; k <= QW; k++) begin : g_div
		localparam int POS = QW - k;
		logic [RW:0] trial_w;
		logic        take_w;
		assign trial_w = (RW+1)'(dv_dm_s[k-1]) << POS;
		assign take_w  = ({1'b0, dv_rem_s[k-1]} >= trial_w);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k] <= 1'b0;
			end else if (en) begin
				dv_vld_s[k] <= dv_vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_it_s[k]   <= dv_it_s[k-1];
				dv_rem_s[k]  <= take_w ? RW'({1'b0, dv_rem_s[k-1]} - trial_w) : dv_rem_s[k-1];
				dv_q_s[k]    <= dv_q_s[k-1] | (take_w ? QW'(1) << POS : QW'(0));
				dv_dm_s[k]   <= dv_dm_s[k-1];
				dv_neg_s[k]  <= dv_neg_s[k-1];
				dv_flat_s[k] <= dv_flat_s[k-1];
				dv_ovf_s[k]  <= dv_ovf_s[k-1];
			end
		end
	end

	// Final stage: apply the step and clamp u to [0, 1]; a done item or flat slope sets done instead.
	logic [QW:0]         qm_w;
	logic signed [QW+2:0] q_w, un_w;
	logic [UW-1:0]       unew_w;
	cbe_pkg::cbe_item_t  fin_w;
	assign qm_w = dv_ovf_s[QW] ? (QW+1)'(1) << QW : {1'b0, dv_q_s[QW]};
	assign q_w  = dv_neg_s[QW] ? -$signed((QW+3)'(qm_w)) : $signed((QW+3)'(qm_w));
	assign un_w = $signed((QW+3)'(dv_it_s[QW].u)) - q_w;

	always_comb begin
		if (un_w < 0) begin
			unew_w = '0;
		end else if (un_w > (QW+3)'(cbe_pkg::ONE)) begin
			unew_w = UW'(cbe_pkg::ONE);
		end else begin
			unew_w = UW'(un_w);
		end
		fin_w = dv_it_s[QW];
		if (dv_it_s[QW].done || dv_flat_s[QW]) begin
			fin_w.done = 1'b1;
		end else begin
			fin_w.u = unew_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= dv_vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item <= fin_w;
		end
	end

endmodule

>>> src/cubic_bezier_easing_unit.sv
// From an accepted item to its result: 22 stages per Newton step, set by the
// one-bit-per-stage quotient chain, plus input clamp and four y stages.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset clears all valid bits and loads the control points to their defaults.
// ----------------------------------------------------------------------------
// cubic_bezier_easing_unit
// Cubic Bezier easing curve: solves x(u) = time by Newton steps, then returns
// y(u) saturated to the signed 16-bit output range.
// ----------------------------------------------------------------------------
module cubic_bezier_easing_unit #(
	parameter int NEWTON_STEPS = cbe_pkg::NEWTON_STEPS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] time_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] eased_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int PW = cbe_pkg::PW;
	localparam int UW = cbe_pkg::UW;

	// The pipeline advances unless a finished result is held.
	logic en;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	logic [UW-1:0] ctrl1_x_q, ctrl2_x_q;
	logic [15:0]   ctrl1_y_q, ctrl2_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl1_x_q <= '0;
			ctrl1_y_q <= '0;
			ctrl2_x_q <= '0;
			ctrl2_y_q <= 16'(cbe_pkg::ONE);
		end else if (cfg_valid) begin
			case (cfg_index)
				cbe_pkg::CFG_CTRL1_X: ctrl1_x_q <= cfg_data[UW-1:0];
				cbe_pkg::CFG_CTRL1_Y: ctrl1_y_q <= cfg_data;
				cbe_pkg::CFG_CTRL2_X: ctrl2_x_q <= cfg_data[UW-1:0];
				cbe_pkg::CFG_CTRL2_Y: ctrl2_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage: clamp the time to [0, 1] and start u at the time.
	logic               vld_s0;
	cbe_pkg::cbe_item_t it_s0;
	logic [UW-1:0]      tcl_w;

	always_comb begin
		if (time_in[15]) begin
			tcl_w = '0;
		end else if (time_in > 16'(cbe_pkg::ONE)) begin
			tcl_w = UW'(cbe_pkg::ONE);
		end else begin
			tcl_w = time_in[UW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (en) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s0.t    <= tcl_w;
			it_s0.u    <= tcl_w;
			it_s0.done <= 1'b0;
		end
	end

	// Chain of Newton steps.
	logic               nv_vld [0:NEWTON_STEPS];
	cbe_pkg::cbe_item_t nv_it  [0:NEWTON_STEPS];
	assign nv_vld[0] = vld_s0;
	assign nv_it[0]  = it_s0;

	for (genvar i = 0; i < NEWTON_STEPS; i++) begin : g_step
		cbe_newton u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (nv_vld[i]),
			.in_item  (nv_it[i]),
			.x1       (ctrl1_x_q),
			.x2       (ctrl2_x_q),
			.out_vld  (nv_vld[i+1]),
			.out_item (nv_it[i+1])
		);
	end

	// Y stage 1: basis terms at the solved u.
	logic                 vld_y1;
	logic signed [PW-1:0] u_y1, inv_y1, a_y1, b_y1;
	logic signed [PW-1:0] us_w, invs_w;
	assign us_w   = PW'(nv_it[NEWTON_STEPS].u);
	assign invs_w = PW'(cbe_pkg::ONE) - us_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_y1 <= 1'b0;
		end else if (en) begin
			vld_y1 <= nv_vld[NEWTON_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_y1   <= us_w;
			inv_y1 <= invs_w;
			a_y1   <= cbe_pkg::fx_mul(invs_w, invs_w);
			b_y1   <= cbe_pkg::fx_mul(us_w, us_w);
		end
	end

	// Y stage 2: cubic basis products.
	logic                 vld_y2;
	logic signed [PW-1:0] au_y2, invb_y2, bu_y2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_y2 <= 1'b0;
		end else if (en) begin
			vld_y2 <= vld_y1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			au_y2   <= cbe_pkg::fx_mul(a_y1, u_y1);
			invb_y2 <= cbe_pkg::fx_mul(inv_y1, b_y1);
			bu_y2   <= cbe_pkg::fx_mul(b_y1, u_y1);
		end
	end

	// Y stage 3: weight by the control point y values.
	logic                 vld_y3;
	logic signed [PW-1:0] ya_y3, yb_y3, bu_y3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_y3 <= 1'b0;
		end else if (en) begin
			vld_y3 <= vld_y2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ya_y3 <= cbe_pkg::fx_mul(au_y2, PW'($signed(ctrl1_y_q)));
			yb_y3 <= cbe_pkg::fx_mul(invb_y2, PW'($signed(ctrl2_y_q)));
			bu_y3 <= bu_y2;
		end
	end

	// Output stage: sum and saturate.
	logic signed [PW-1:0] ysum_w;
	logic [15:0]          ysat_w;
	assign ysum_w = PW'(3 * ya_y3 + 3 * yb_y3 + bu_y3);

	always_comb begin
		if (ysum_w < -PW'(32768)) begin
			ysat_w = 16'h8000;
		end else if (ysum_w > PW'(32767)) begin
			ysat_w = 16'h7fff;
		end else begin
			ysat_w = ysum_w[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_y3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eased_out <= ysat_w;
		end
	end

endmodule

>>> src/cbe_checker.sv
// ----------------------------------------------------------------------------
// cbe_checker
// Port-level checks for the cubic Bezier easing unit, bound to the top level.
// ----------------------------------------------------------------------------
module cbe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] eased_out,
	input logic        cfg_ready
);

	// A held result keeps its valid and its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(eased_out))
		else $error("held result changed");

	// The input stalls exactly when a finished result is held.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow the held result");

	// Configuration writes are always taken.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind cubic_bezier_easing_unit cbe_checker u_cbe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.eased_out (eased_out),
	.cfg_ready (cfg_ready)
);

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cubic Bezier easing unit. Time items are sent
// under random idling, each expected eased value is computed by a fixed-point
// Newton solver in the bench, and results are compared in order.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LATENCY   = 5 + 22 * cbe_pkg::NEWTON_STEPS;
	localparam int MAX_CYCLE = 3000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] time_in;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] eased_out;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	// Bench copy of the control points.
	longint      p1x, p1y, p2x, p2y;
	logic [15:0] eased_queue[$];
	int          errors;
	int          cycle;
	bit          calm;
	int          hold_off;
	int          idle_pct;

	cubic_bezier_easing_unit dut (.*);

	always #1 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > MAX_CYCLE) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic longint qmul(longint a, longint b);
		longint m;
		m = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + (1 << (cbe_pkg::FRAC_BITS - 1)))
			>>> cbe_pkg::FRAC_BITS;
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	function automatic longint qdiv(longint n, longint d);
		longint un, ud, q;
		un = (n < 0 ? -n : n) << cbe_pkg::FRAC_BITS;
		ud = d < 0 ? -d : d;
		if (ud == 0)
			return 0;
		q = (un + ud / 2) / ud;
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic longint curve(longint u, longint c1, longint c2);
		longint inv, a, b;
		inv = cbe_pkg::ONE - u;
		a = qmul(inv, inv);
		b = qmul(u, u);
		return 3 * qmul(qmul(a, u), c1) + 3 * qmul(qmul(inv, b), c2) + qmul(b, u);
	endfunction

	function automatic longint slope(longint u, longint c1, longint c2);
		longint inv, a, b;
		inv = cbe_pkg::ONE - u;
		a = qmul(inv, inv);
		b = qmul(u, u);
		return 3 * qmul(a, c1) + 6 * qmul(qmul(inv, u), c2 - c1)
			+ 3 * qmul(b, cbe_pkg::ONE - c2);
	endfunction

	// Expected eased value for one time item.
	function automatic logic [15:0] eased_value(logic [15:0] tin);
		longint t, u, xv, dx, y;
		t = longint'($signed(tin));
		t = t < 0 ? 0 : (t > cbe_pkg::ONE ? cbe_pkg::ONE : t);
		u = t;
		for (int i = 0; i < cbe_pkg::NEWTON_STEPS; i++) begin
			xv = curve(u, p1x, p2x);
			dx = slope(u, p1x, p2x);
			if (dx > -cbe_pkg::SLOPE_MIN && dx < cbe_pkg::SLOPE_MIN)
				break;
			u = u - qdiv(xv - t, dx);
			u = u < 0 ? 0 : (u > cbe_pkg::ONE ? cbe_pkg::ONE : u);
		end
		y = curve(u, p1y, p2y);
		y = y < -32768 ? -32768 : (y > 32767 ? 32767 : y);
		return y[15:0];
	endfunction

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (eased_queue.size() == 0) begin
				$display("%0t: unexpected item, actual %0d", $time, $signed(eased_out));
				errors++;
			end else begin
				if (eased_queue[0] !== eased_out) begin
					$display("%0t: eased_out mismatch, expected %0d, actual %0d", $time,
						$signed(eased_queue[0]), $signed(eased_out));
					errors++;
				end
				void'(eased_queue.pop_front());
			end
		end
	end

	// Receiver stall, with a counted hold-off on request.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < idle_pct);
	end

	// The item stays offered after acceptance until the next send or a drain
	// takes valid down, so back-to-back items see a single update per edge.
	task automatic send_time(logic [15:0] v);
		if (!calm)
			while ($urandom_range(99) < idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		time_in  <= v;
		do
			@(posedge clk);
		while (in_stall);
		eased_queue.push_back(eased_value(v));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (eased_queue.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			cbe_pkg::CFG_CTRL1_X: p1x = longint'(val[14:0]);
			cbe_pkg::CFG_CTRL1_Y: p1y = longint'($signed(val));
			cbe_pkg::CFG_CTRL2_X: p2x = longint'(val[14:0]);
			cbe_pkg::CFG_CTRL2_Y: p2y = longint'($signed(val));
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_curve(logic [15:0] ax, logic [15:0] ay, logic [15:0] bx,
			logic [15:0] by);
		drain();
		write_reg(cbe_pkg::CFG_CTRL1_X, ax);
		write_reg(cbe_pkg::CFG_CTRL1_Y, ay);
		write_reg(cbe_pkg::CFG_CTRL2_X, bx);
		write_reg(cbe_pkg::CFG_CTRL2_Y, by);
	endtask

	function automatic logic [15:0] random_time();
		case ($urandom_range(9))
			0: return 16'($urandom);
			1: return 16'($urandom_range(3));
			2: return 16'(cbe_pkg::ONE - $urandom_range(3));
			default: return 16'($urandom_range(cbe_pkg::ONE));
		endcase
	endfunction

	// Extremes of time, including out-of-range values, on the reset curve.
	task automatic test_time_extremes();
		logic [15:0] vals[12] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h2000,
			16'h3FFF, 16'h4000, 16'h4001, 16'h7FFF, 16'h5555, 16'hAAAA, 16'h1234};
		foreach (vals[i])
			send_time(vals[i]);
	endtask

	// Flat slope, control x above one and extreme control y values.
	task automatic test_special_curves();
		set_curve(16'h0000, 16'h7FFF, 16'h4000, 16'h7FFF);
		send_time(16'h0000);
		send_time(16'h2000);
		send_time(16'h4000);
		set_curve(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
		send_time(16'h1000);
		send_time(16'h3000);
		set_curve(16'h4000, 16'h0000, 16'h0000, 16'h4000);
		send_time(16'h0000);
		send_time(16'h4000);
		send_time(16'h2000);
	endtask

	// Random curves with random times, including a stretch with no idling.
	task automatic test_random_curves();
		for (int s = 0; s < 18; s++) begin
			if (s % 3 == 0)
				set_curve(16'($urandom_range(16384)), 16'($urandom), 16'($urandom_range(16384)),
					16'($urandom));
			else
				set_curve(16'($urandom_range(32767)), 16'($urandom), 16'($urandom_range(32767)),
					16'($urandom));
			calm = (s == 5);
			repeat (90)
				send_time(random_time());
			calm = 1'b0;
		end
	endtask

	// Receiver holds off while items keep coming, then the sender pauses.
	task automatic test_backpressure();
		set_curve(16'd6881, 16'd1638, 16'd4096, 16'd16384);
		@(posedge clk);
		hold_off <= 400;
		repeat (200)
			send_time(random_time());
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		time_in = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = cbe_pkg::CFG_CTRL1_X;
		cfg_data = '0;
		errors = 0;
		cycle = 0;
		calm = 1'b0;
		hold_off = 0;
		idle_pct = 34;
		p1x = 0;
		p1y = 0;
		p2x = 0;
		p2y = 16384;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_time_extremes();
		test_special_curves();
		test_random_curves();
		test_backpressure();
		drain();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
